// ----- sv/utx_pkg.sv -----
// Shared types and constants for the UTF-8 / UTF-16BE transcoder.
`timescale 1ns / 1ps

package utx_pkg;

    // conversion modes
    localparam logic [2:0] MODE_U8_U16    = 3'd0;
    localparam logic [2:0] MODE_U16_U8    = 3'd1;
    localparam logic [2:0] MODE_U8_ASCII  = 3'd2;
    localparam logic [2:0] MODE_U16_ASCII = 3'd3;
    localparam logic [2:0] MODE_L1_U16    = 3'd4;

    // result kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_SUB_CHAR = 1'b1;

    localparam logic [6:0] SUB_CHAR_RESET = 7'h3f;
    localparam int         BURST_MAX      = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] sub_char;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
    } entry_t;

    // all results caused by one input byte
    typedef struct packed {
        entry_t [BURST_MAX-1:0] ent;
        logic [1:0]             last_idx;
    } burst_t;

endpackage

// ----- sv/utx_front.sv -----
// Front end: accepts source bytes, runs the decoder state and builds result bursts.
`timescale 1ns / 1ps

module utx_front (
    input  logic               clk,
    input  logic               rst_n,
    input  utx_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  utx_pkg::in_item_t  in_item,
    input  logic               q_full,
    output logic               push,
    output utx_pkg::burst_t    push_burst
);

    logic [30:0] code_point_reg, code_point_next;
    logic [2:0]  bytes_due_reg, bytes_due_next;
    logic        utf16_phase_reg, utf16_phase_next;
    logic [9:0]  high_surrogate_reg, high_surrogate_next;
    logic        have_high_reg, have_high_next;
    logic        error_seen_reg, error_seen_next;

    logic        accept;
    logic [2:0]  n;
    utx_pkg::burst_t bst;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        logic [7:0]  b;
        logic        fault;
        logic        dl_en;
        logic [30:0] dl_cp;
        logic [15:0] u;
        logic [20:0] sup;
        logic [19:0] v;

        b     = in_item.in_byte;
        fault = 1'b0;
        dl_en = 1'b0;
        dl_cp = '0;
        u     = '0;
        sup   = '0;
        v     = '0;
        n     = '0;
        bst   = '0;

        code_point_next     = code_point_reg;
        bytes_due_next      = bytes_due_reg;
        utf16_phase_next    = utf16_phase_reg;
        high_surrogate_next = high_surrogate_reg;
        have_high_next      = have_high_reg;
        error_seen_next     = error_seen_reg;

        if (!error_seen_reg)
        begin
            unique case (cfg.mode)
                utx_pkg::MODE_U8_U16, utx_pkg::MODE_U8_ASCII:
                begin
                    if (bytes_due_reg == 3'd0)
                    begin
                        priority if (b < 8'h80)
                        begin
                            dl_en = 1'b1;
                            dl_cp = {23'd0, b};
                        end
                        else if (b < 8'hc0 || b >= 8'hfe)
                            fault = 1'b1;
                        else if (b >= 8'hfc)
                        begin
                            bytes_due_next  = 3'd5;
                            code_point_next = {30'd0, b[0]};
                        end
                        else if (b >= 8'hf8)
                        begin
                            bytes_due_next  = 3'd4;
                            code_point_next = {29'd0, b[1:0]};
                        end
                        else if (b >= 8'hf0)
                        begin
                            bytes_due_next  = 3'd3;
                            code_point_next = {28'd0, b[2:0]};
                        end
                        else if (b >= 8'he0)
                        begin
                            bytes_due_next  = 3'd2;
                            code_point_next = {27'd0, b[3:0]};
                        end
                        else
                        begin
                            bytes_due_next  = 3'd1;
                            code_point_next = {26'd0, b[4:0]};
                        end
                    end
                    else if (b[7:6] != 2'b10)
                        fault = 1'b1;
                    else
                    begin
                        bytes_due_next = bytes_due_reg - 3'd1;
                        if (bytes_due_reg == 3'd1)
                        begin
                            dl_en           = 1'b1;
                            dl_cp           = {code_point_reg[24:0], b[5:0]};
                            code_point_next = '0;
                        end
                        else
                            code_point_next = {code_point_reg[24:0], b[5:0]};
                    end
                end
                utx_pkg::MODE_U16_U8, utx_pkg::MODE_U16_ASCII:
                begin
                    if (!utf16_phase_reg)
                    begin
                        code_point_next  = {23'd0, b};
                        utf16_phase_next = 1'b1;
                    end
                    else
                    begin
                        u                = {code_point_reg[7:0], b};
                        utf16_phase_next = 1'b0;
                        code_point_next  = '0;
                        priority if (u[15:10] == 6'b110110)
                        begin
                            if (have_high_reg)
                                fault = 1'b1;
                            else
                            begin
                                high_surrogate_next = u[9:0];
                                have_high_next      = 1'b1;
                            end
                        end
                        else if (u[15:10] == 6'b110111)
                        begin
                            if (!have_high_reg)
                                fault = 1'b1;
                            else
                            begin
                                sup = {1'b0, high_surrogate_reg, u[9:0]} + 21'h10000;
                                dl_en               = 1'b1;
                                dl_cp               = {10'd0, sup};
                                have_high_next      = 1'b0;
                                high_surrogate_next = '0;
                            end
                        end
                        else if (have_high_reg)
                            fault = 1'b1;
                        else
                        begin
                            dl_en = 1'b1;
                            dl_cp = {15'd0, u};
                        end
                    end
                end
                utx_pkg::MODE_L1_U16:
                begin
                    n               = 3'd2;
                    bst.ent[0].data = 8'h00;
                    bst.ent[1].data = b;
                end
                default:
                begin
                end
            endcase

            if (dl_en)
            begin
                unique case (cfg.mode)
                    utx_pkg::MODE_U8_U16:
                    begin
                        if ((dl_cp >= 31'hd800 && dl_cp <= 31'hdfff) || dl_cp > 31'h10ffff)
                            fault = 1'b1;
                        else if (dl_cp < 31'h10000)
                        begin
                            n               = 3'd2;
                            bst.ent[0].data = dl_cp[15:8];
                            bst.ent[1].data = dl_cp[7:0];
                        end
                        else
                        begin
                            v               = dl_cp[19:0] - 20'h10000;
                            n               = 3'd4;
                            bst.ent[0].data = {6'b110110, v[19:18]};
                            bst.ent[1].data = v[17:10];
                            bst.ent[2].data = {6'b110111, v[9:8]};
                            bst.ent[3].data = v[7:0];
                        end
                    end
                    utx_pkg::MODE_U16_U8:
                    begin
                        priority if (dl_cp < 31'h80)
                        begin
                            n               = 3'd1;
                            bst.ent[0].data = dl_cp[7:0];
                        end
                        else if (dl_cp < 31'h800)
                        begin
                            n               = 3'd2;
                            bst.ent[0].data = {3'b110, dl_cp[10:6]};
                            bst.ent[1].data = {2'b10, dl_cp[5:0]};
                        end
                        else if (dl_cp < 31'h10000)
                        begin
                            n               = 3'd3;
                            bst.ent[0].data = {4'b1110, dl_cp[15:12]};
                            bst.ent[1].data = {2'b10, dl_cp[11:6]};
                            bst.ent[2].data = {2'b10, dl_cp[5:0]};
                        end
                        else
                        begin
                            n               = 3'd4;
                            bst.ent[0].data = {5'b11110, dl_cp[20:18]};
                            bst.ent[1].data = {2'b10, dl_cp[17:12]};
                            bst.ent[2].data = {2'b10, dl_cp[11:6]};
                            bst.ent[3].data = {2'b10, dl_cp[5:0]};
                        end
                    end
                    default:
                    begin
                        n               = 3'd1;
                        bst.ent[0].data = (dl_cp < 31'h80) ? dl_cp[7:0] : {1'b0, cfg.sub_char};
                    end
                endcase
            end

            if (fault)
            begin
                n                   = 3'd1;
                bst.ent[0].data     = 8'h00;
                bst.ent[0].kind     = utx_pkg::KIND_ERROR;
                error_seen_next     = 1'b1;
                code_point_next     = '0;
                bytes_due_next      = '0;
                utf16_phase_next    = 1'b0;
                high_surrogate_next = '0;
                have_high_next      = 1'b0;
            end

            // truncated at end; dropped when the burst is already full
            if (in_item.end_of_string && !error_seen_next &&
                (bytes_due_next != 3'd0 || utf16_phase_next || have_high_next))
            begin
                if (n < 3'd4)
                begin
                    bst.ent[n[1:0]].data = 8'h00;
                    bst.ent[n[1:0]].kind = utx_pkg::KIND_ERROR;
                    n                    = n + 3'd1;
                end
                error_seen_next = 1'b1;
            end
        end

        if (in_item.end_of_string)
        begin
            code_point_next     = '0;
            bytes_due_next      = '0;
            utf16_phase_next    = 1'b0;
            high_surrogate_next = '0;
            have_high_next      = 1'b0;
            error_seen_next     = 1'b0;
        end

        bst.last_idx = n[1:0] - 2'd1;
    end

    assign push       = accept && (n != 3'd0);
    assign push_burst = bst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_point_reg     <= '0;
            bytes_due_reg      <= '0;
            utf16_phase_reg    <= 1'b0;
            high_surrogate_reg <= '0;
            have_high_reg      <= 1'b0;
            error_seen_reg     <= 1'b0;
        end
        else if (accept)
        begin
            code_point_reg     <= code_point_next;
            bytes_due_reg      <= bytes_due_next;
            utf16_phase_reg    <= utf16_phase_next;
            high_surrogate_reg <= high_surrogate_next;
            have_high_reg      <= have_high_next;
            error_seen_reg     <= error_seen_next;
        end
    end

endmodule

// ----- sv/utx_queue.sv -----
// Short queue of result bursts between the front end and the output serializer.
`timescale 1ns / 1ps

module utx_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utx_pkg::burst_t push_burst,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output utx_pkg::burst_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    utx_pkg::burst_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_burst;
    end

endmodule

// ----- sv/utx_back.sv -----
// Back end: walks each burst and presents its results one transfer per cycle while out_stall is low.
`timescale 1ns / 1ps

module utx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  utx_pkg::burst_t    head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output utx_pkg::out_item_t out_item
);

    utx_pkg::burst_t burst_reg;
    logic            busy_reg, busy_next;
    logic [1:0]      idx_reg, idx_next;
    logic            take, take_last;

    assign take      = busy_reg && !out_stall;
    assign take_last = take && (idx_reg == burst_reg.last_idx);
    assign pop       = head_valid && (!busy_reg || take_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take_last)
            busy_next = 1'b0;
        else if (take)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            burst_reg <= head;
    end

    assign out_valid          = busy_reg;
    assign out_item.out_byte  = burst_reg.ent[idx_reg].data;
    assign out_item.kind      = burst_reg.ent[idx_reg].kind;
    assign out_item.last_byte = (idx_reg == burst_reg.last_idx);

endmodule

// ----- sv/utf8_utf16_transcoder_unit.sv -----
// Top level of the UTF-8 / UTF-16BE / ASCII / Latin-1 byte transcoder.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid / in_stall  in_item  (in_byte, end_of_string)
//   out       from block out_valid/out_stall  out_item (out_byte, kind, last_byte)
//   config    to block   APB psel/penable     mode at 0x0, sub_char at 0x4
//
// A source byte is accepted every cycle while the burst queue has room; the decoder
// state updates in that same cycle. The output serializer sends one result per cycle
// while out_stall is low, and a byte causes k results (k = 0..4).
// Sustained throughput is set by the output side when bytes average more than one result.
// Reset clears the decoder state, the queue and the output; mode = 0, sub_char = 0x3f.
// A stalled output only backs up the input once QUEUE_DEPTH bursts are waiting.
`timescale 1ns / 1ps

module utf8_utf16_transcoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  utx_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output utx_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [2:0]      mode_reg;
    logic [6:0]      sub_char_reg;
    utx_pkg::cfg_t   cfg;
    logic            wr_en;

    logic            q_full, q_push, q_pop, q_head_valid;
    utx_pkg::burst_t q_push_burst, q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= utx_pkg::MODE_U8_U16;
            sub_char_reg <= utx_pkg::SUB_CHAR_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                utx_pkg::REG_MODE:     mode_reg     <= pwdata[2:0];
                utx_pkg::REG_SUB_CHAR: sub_char_reg <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            utx_pkg::REG_MODE:     prdata = {29'd0, mode_reg};
            utx_pkg::REG_SUB_CHAR: prdata = {25'd0, sub_char_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.mode     = mode_reg;
    assign cfg.sub_char = sub_char_reg;

    utx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .q_full     (q_full),
        .push       (q_push),
        .push_burst (q_push_burst)
    );

    utx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_burst (q_push_burst),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    utx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// ----- sv/utx_checker.sv -----
// Port-level checks for the transcoder, bound to the top level.
`timescale 1ns / 1ps

module utx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input utx_pkg::out_item_t out_item
);

    // a stalled transfer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("out_item changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == utx_pkg::KIND_ERROR |-> out_item.out_byte == 8'h00)
        else $error("error result carries nonzero byte");

    // an error always closes the results of its input byte
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == utx_pkg::KIND_ERROR |-> out_item.last_byte)
        else $error("error result is not the last of its burst");

endmodule

bind utf8_utf16_transcoder_unit utx_checker u_utx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
